### hdl/lpd_pkg.sv
// Package for the length-prefix deframer.
// Holds the length width, prefix mode codes and the result record type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

  // Width kept from an assembled length (16 to 32)
  localparam int LENGTH_BITS = 32;
  // Prefix bytes are assembled into a full four-byte word
  localparam int ACCUM_BITS  = 32;

  typedef enum logic [1:0] {
    MODE_RAW    = 2'd0,
    MODE_PFX2   = 2'd1,
    MODE_PFX4   = 2'd2,
    MODE_UNUSED = 2'd3
  } prefix_mode_t;

  // Prefix sizes as length values
  localparam logic [LENGTH_BITS-1:0] PSIZE2 = LENGTH_BITS'(2);
  localparam logic [LENGTH_BITS-1:0] PSIZE4 = LENGTH_BITS'(4);

  // One result item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
    logic       empty_frame;
    logic       length_error;
  } result_t;

endpackage

`default_nettype wire

### hdl/lpd_in_reg.sv
// Input register stage of the length-prefix deframer.
// Captures one byte per transfer and holds it while the next stage is busy.
// Depends on nothing but the downstream advance signal.
`timescale 1ns / 1ps
`default_nettype none

module lpd_in_reg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       advance,
  output logic            held_valid,
  output logic [7:0]      held_byte
);

  logic held_valid_next;

  // Stall only while a held byte cannot move on
  assign in_stall        = held_valid && !advance;
  assign held_valid_next = in_stall ? held_valid : in_valid;

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  // Capture payload on each input transfer
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= in_byte;
    end
  end

endmodule

`default_nettype wire

### hdl/lpd_framer.sv
// Framing state and decode logic of the length-prefix deframer.
// Holds the mode register, prefix assembly and body countdown.
// Depends on lpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpd_framer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write_en,
  input  wire logic [1:0]      cfg_mode,
  input  wire logic            step,
  input  wire logic [7:0]      step_byte,
  output logic                 res_valid,
  output lpd_pkg::result_t     res
);
  import lpd_pkg::*;

  logic [1:0]             prefix_mode;
  logic                   in_body;
  logic [1:0]             prefix_count;
  logic [ACCUM_BITS-1:0]  length_accum;
  logic [LENGTH_BITS-1:0] bytes_remaining;

  logic                   in_body_next;
  logic [1:0]             prefix_count_next;
  logic [ACCUM_BITS-1:0]  length_accum_next;
  logic [LENGTH_BITS-1:0] bytes_remaining_next;

  logic                   framed;
  logic [LENGTH_BITS-1:0] psize;
  logic [1:0]             count_inc;
  logic                   prefix_done;
  logic [ACCUM_BITS-1:0]  accum_merged;
  logic [LENGTH_BITS-1:0] frame_len;
  logic [LENGTH_BITS-1:0] rem_dec;

  // Decode mode into prefix size
  always_comb begin
    framed = 1'b1;
    psize  = PSIZE2;
    unique case (prefix_mode)
      MODE_PFX2: psize = PSIZE2;
      MODE_PFX4: psize = PSIZE4;
      default:   framed = 1'b0;
    endcase
  end

  // Merge the incoming byte into the little-endian length
  always_comb begin
    accum_merged = length_accum;
    unique case (prefix_count)
      2'd0: accum_merged[7:0]   = length_accum[7:0]   | step_byte;
      2'd1: accum_merged[15:8]  = length_accum[15:8]  | step_byte;
      2'd2: accum_merged[23:16] = length_accum[23:16] | step_byte;
      default: accum_merged[31:24] = length_accum[31:24] | step_byte;
    endcase
  end

  assign count_inc   = prefix_count + 2'd1;
  assign prefix_done = (prefix_mode == MODE_PFX2) ? (count_inc == 2'd2)
                                                   : (count_inc == 2'd0);
  assign frame_len   = accum_merged[LENGTH_BITS-1:0];
  assign rem_dec     = bytes_remaining - LENGTH_BITS'(1);

  // Work out the result and next framing state for one byte
  always_comb begin
    in_body_next         = in_body;
    prefix_count_next    = prefix_count;
    length_accum_next    = length_accum;
    bytes_remaining_next = bytes_remaining;
    res_valid            = 1'b0;
    res                  = '0;
    if (step) begin
      if (!framed) begin
        res_valid     = 1'b1;
        res.data_byte = step_byte;
      end else if (in_body) begin
        bytes_remaining_next = rem_dec;
        res_valid            = 1'b1;
        res.data_byte        = step_byte;
        if (rem_dec == '0) begin
          in_body_next   = 1'b0;
          res.frame_last = 1'b1;
        end
      end else if (!prefix_done) begin
        length_accum_next = accum_merged;
        prefix_count_next = count_inc;
      end else begin
        length_accum_next = '0;
        prefix_count_next = 2'd0;
        if (frame_len < psize) begin
          res_valid        = 1'b1;
          res.length_error = 1'b1;
        end else if (frame_len == psize) begin
          res_valid       = 1'b1;
          res.empty_frame = 1'b1;
        end else begin
          bytes_remaining_next = frame_len - psize;
          in_body_next         = 1'b1;
        end
      end
    end
  end

  // Hold mode and framing state; a mode write restarts framing
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_mode     <= MODE_RAW;
      in_body         <= 1'b0;
      prefix_count    <= 2'd0;
      length_accum    <= '0;
      bytes_remaining <= '0;
    end else if (cfg_write_en) begin
      prefix_mode     <= cfg_mode;
      in_body         <= 1'b0;
      prefix_count    <= 2'd0;
      length_accum    <= '0;
      bytes_remaining <= '0;
    end else begin
      in_body         <= in_body_next;
      prefix_count    <= prefix_count_next;
      length_accum    <= length_accum_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

`default_nettype wire

### hdl/lpd_out_reg.sv
// Output register stage of the length-prefix deframer.
// Holds one result until the receiver takes it; tells the input stage when to advance.
// Depends on lpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              res_valid,
  input  wire lpd_pkg::result_t  res,
  output logic                   advance,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lpd_pkg::result_t       out_res
);
  import lpd_pkg::*;

  logic load;
  logic out_valid_next;

  // Advance when the register is empty or being drained this cycle
  assign advance = !out_valid || !out_stall;
  assign load    = advance && res_valid;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (advance) begin
      out_valid_next = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Capture result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

### hdl/length_prefix_deframer.sv
// Length-prefix deframer: splits a byte stream into little-endian length-prefixed frames.
// Top level over lpd_in_reg, lpd_framer and lpd_out_reg; uses lpd_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_byte) takes one stream byte per transfer.
//   Output channel (out_valid / out_stall) delivers data_byte with frame_last,
//   empty_frame and length_error flags. Prefix bytes that do not finish a frame
//   header, and a header that opens a non-empty body, deliver nothing.
//   prefix_mode is written with cfg_write_en while the block is idle: 0 raw
//   passthrough, 1 two-byte prefix, 2 four-byte prefix, 3 acts as raw. Any write
//   restarts framing at a prefix.
// Timing:
//   One byte accepted per cycle while in_stall is low. An accepted byte goes through
//   the input register, one pass of framing logic and the output register before
//   its result reaches the output channel.
// Reset (rst, synchronous): raw mode, framing cleared, both stages empty.
// Stall: a result waits in the output register; one more byte is held in the
//   input register, after which in_stall rises until the receiver takes the result.
`timescale 1ns / 1ps
`default_nettype none

module length_prefix_deframer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_en,
  input  wire logic [1:0] prefix_mode,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      data_byte,
  output logic            frame_last,
  output logic            empty_frame,
  output logic            length_error
);
  import lpd_pkg::*;

  logic       advance;
  logic       held_valid;
  logic [7:0] held_byte;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  lpd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  lpd_framer u_framer (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_mode     (prefix_mode),
    .step         (held_valid && advance),
    .step_byte    (held_byte),
    .res_valid    (res_valid),
    .res          (res)
  );

  lpd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // Split the result record onto the ports
  assign data_byte    = out_res.data_byte;
  assign frame_last   = out_res.frame_last;
  assign empty_frame  = out_res.empty_frame;
  assign length_error = out_res.length_error;

  // Input backs up only behind a full, stalled output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A result carries at most one marker flag
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones({frame_last, empty_frame, length_error}) <= 1))
    else $error("more than one marker flag set");

  // Marker-only results carry a zero data byte
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (empty_frame || length_error)) |-> (data_byte == 8'd0))
    else $error("marker result with nonzero data");

endmodule

`default_nettype wire
